// ----- rtl/core/wsd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared opcodes, result kinds and item types for the frame deframer.
// ----------------------------------------------------------------------------
package wsd_pkg;

    localparam logic [3:0] OPC_CLOSE = 4'h8;
    localparam logic [3:0] OPC_PING  = 4'h9;
    localparam logic [3:0] OPC_PONG  = 4'hA;

    localparam logic [2:0] KIND_DATA       = 3'd0;
    localparam logic [2:0] KIND_EMPTY_DATA = 3'd1;
    localparam logic [2:0] KIND_CLOSE      = 3'd2;
    localparam logic [2:0] KIND_PING_BYTE  = 3'd3;
    localparam logic [2:0] KIND_EMPTY_PING = 3'd4;

    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    // Registered input item handed from the input stage to the parser.
    typedef struct packed {
        logic       valid;
        logic [7:0] rx_byte;
    } in_item_t;

endpackage
`default_nettype wire

// ----- rtl/core/wsd_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wsd_in_if
// Byte stream channel: valid/ready handshake with one received byte.
// ----------------------------------------------------------------------------
interface wsd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/wsd_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wsd_out_if
// Result channel: valid/ready handshake with one deframed result item.
// ----------------------------------------------------------------------------
interface wsd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [3:0] frame_opcode;
    logic [2:0] result_kind;
    logic       last_of_frame;

    modport source (output valid, output out_byte, output frame_opcode,
                    output result_kind, output last_of_frame, input ready);
    modport sink   (input valid, input out_byte, input frame_opcode,
                    input result_kind, input last_of_frame, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/wsd_in_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wsd_in_stage
// Input register: captures one byte and holds it until the parser takes it.
// ----------------------------------------------------------------------------
module wsd_in_stage (
    input  wire logic       clk,
    input  wire logic       rst_n,
    wsd_in_if.sink          stream,
    input  wire logic       advance,
    output wsd_pkg::in_item_t item
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       take;

    assign stream.ready = !valid_reg || advance;
    assign take         = stream.valid && stream.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (advance)
        begin
            valid_next = 1'b0;
        end
        if (take)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            byte_reg <= stream.rx_byte;
        end
    end

    assign item = '{valid: valid_reg, rx_byte: byte_reg};

endmodule
`default_nettype wire

// ----- rtl/core/wsd_parser.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wsd_parser
// Frame state machine, unmasking and result register.
// ----------------------------------------------------------------------------
module wsd_parser (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire wsd_pkg::in_item_t item,
    output logic             advance,
    wsd_out_if.source        result
);

    typedef enum logic [2:0] {
        PH_HDR0  = 3'd0,
        PH_HDR1  = 3'd1,
        PH_EXT16 = 3'd2,
        PH_EXT64 = 3'd3,
        PH_KEY   = 3'd4,
        PH_DATA  = 3'd5
    } phase_t;

    phase_t      phase_reg,     phase_next;
    logic [3:0]  opcode_reg,    opcode_next;
    logic        mask_reg,      mask_next;
    logic [2:0]  ext_idx_reg,   ext_idx_next;
    logic [63:0] remain_reg,    remain_next;
    logic [31:0] key_reg,       key_next;
    logic [1:0]  key_pos_reg,   key_pos_next;
    logic        link_open_reg, link_open_next;

    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_byte_reg,  out_byte_next;
    logic [3:0]  out_opc_reg,   out_opc_next;
    logic [2:0]  out_kind_reg,  out_kind_next;
    logic        out_last_reg,  out_last_next;

    logic        emit;
    logic        len_done;
    logic        hdr_done;
    logic        end_marker;
    logic        data_last;
    logic [7:0]  b;
    logic [7:0]  key_byte;

    assign advance = item.valid && (!out_valid_reg || result.ready);
    assign b       = item.rx_byte;

    always_comb
    begin
        phase_next     = phase_reg;
        opcode_next    = opcode_reg;
        mask_next      = mask_reg;
        ext_idx_next   = ext_idx_reg;
        remain_next    = remain_reg;
        key_next       = key_reg;
        key_pos_next   = key_pos_reg;
        link_open_next = link_open_reg;
        emit           = 1'b0;
        out_byte_next  = 8'd0;
        out_kind_next  = wsd_pkg::KIND_DATA;
        out_last_next  = 1'b1;
        len_done       = 1'b0;
        hdr_done       = 1'b0;
        end_marker     = 1'b0;
        data_last      = 1'b0;
        key_byte       = 8'd0;

        if (advance && link_open_reg)
        begin
            case (phase_reg)
                PH_HDR1:
                begin
                    mask_next    = b[7];
                    ext_idx_next = 3'd0;
                    remain_next  = 64'd0;
                    if (b[6:0] == wsd_pkg::LEN_EXT16)
                    begin
                        phase_next = PH_EXT16;
                    end
                    else if (b[6:0] == wsd_pkg::LEN_EXT64)
                    begin
                        phase_next = PH_EXT64;
                    end
                    else
                    begin
                        remain_next = {57'd0, b[6:0]};
                        len_done    = 1'b1;
                    end
                end
                PH_EXT16, PH_EXT64:
                begin
                    remain_next  = {remain_reg[55:0], b};
                    ext_idx_next = ext_idx_reg + 3'd1;
                    if ((phase_reg == PH_EXT16 && ext_idx_next == 3'd2) ||
                        (phase_reg == PH_EXT64 && ext_idx_next == 3'd0))
                    begin
                        len_done = 1'b1;
                    end
                end
                PH_KEY:
                begin
                    key_next[8*key_pos_reg +: 8] = key_reg[8*key_pos_reg +: 8] | b;
                    if (key_pos_reg == 2'd3)
                    begin
                        hdr_done = 1'b1;
                    end
                    else
                    begin
                        key_pos_next = key_pos_reg + 2'd1;
                    end
                end
                PH_DATA:
                begin
                    key_byte      = mask_reg ? key_reg[8*key_pos_reg +: 8] : 8'd0;
                    key_pos_next  = key_pos_reg + 2'd1;
                    remain_next   = remain_reg - 64'd1;
                    data_last     = (remain_reg == 64'd1);
                    if (data_last)
                    begin
                        phase_next = PH_HDR0;
                    end
                    out_last_next = data_last;
                    if (opcode_reg == wsd_pkg::OPC_CLOSE)
                    begin
                        if (data_last)
                        begin
                            link_open_next = 1'b0;
                            emit           = 1'b1;
                            out_kind_next  = wsd_pkg::KIND_CLOSE;
                            out_last_next  = 1'b1;
                        end
                    end
                    else if (opcode_reg == wsd_pkg::OPC_PING)
                    begin
                        emit          = 1'b1;
                        out_byte_next = b ^ key_byte;
                        out_kind_next = wsd_pkg::KIND_PING_BYTE;
                    end
                    else if (opcode_reg != wsd_pkg::OPC_PONG)
                    begin
                        emit          = 1'b1;
                        out_byte_next = b ^ key_byte;
                        out_kind_next = wsd_pkg::KIND_DATA;
                    end
                end
                default:
                begin
                    // First header byte; unused phase codes land here too.
                    opcode_next = b[3:0];
                    phase_next  = PH_HDR1;
                end
            endcase

            // Length known: read the key if the mask flag is set.
            if (len_done)
            begin
                if (mask_next)
                begin
                    phase_next   = PH_KEY;
                    key_pos_next = 2'd0;
                    key_next     = 32'd0;
                end
                else
                begin
                    hdr_done = 1'b1;
                end
            end

            // Header complete: go to payload, or close out an empty frame.
            if (hdr_done)
            begin
                key_pos_next = 2'd0;
                if (remain_next == 64'd0)
                begin
                    end_marker = 1'b1;
                end
                else
                begin
                    phase_next = PH_DATA;
                end
            end

            if (end_marker)
            begin
                phase_next    = PH_HDR0;
                out_last_next = 1'b1;
                if (opcode_reg == wsd_pkg::OPC_CLOSE)
                begin
                    link_open_next = 1'b0;
                    emit           = 1'b1;
                    out_kind_next  = wsd_pkg::KIND_CLOSE;
                end
                else if (opcode_reg == wsd_pkg::OPC_PING)
                begin
                    emit          = 1'b1;
                    out_kind_next = wsd_pkg::KIND_EMPTY_PING;
                end
                else if (opcode_reg != wsd_pkg::OPC_PONG)
                begin
                    emit          = 1'b1;
                    out_kind_next = wsd_pkg::KIND_EMPTY_DATA;
                end
            end
        end

        out_opc_next   = opcode_reg;
        out_valid_next = out_valid_reg && !result.ready;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HDR0;
            opcode_reg    <= 4'd0;
            mask_reg      <= 1'b0;
            ext_idx_reg   <= 3'd0;
            remain_reg    <= 64'd0;
            key_reg       <= 32'd0;
            key_pos_reg   <= 2'd0;
            link_open_reg <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            opcode_reg    <= opcode_next;
            mask_reg      <= mask_next;
            ext_idx_reg   <= ext_idx_next;
            remain_reg    <= remain_next;
            key_reg       <= key_next;
            key_pos_reg   <= key_pos_next;
            link_open_reg <= link_open_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_byte_reg <= out_byte_next;
            out_opc_reg  <= out_opc_next;
            out_kind_reg <= out_kind_next;
            out_last_reg <= out_last_next;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.out_byte      = out_byte_reg;
    assign result.frame_opcode  = out_opc_reg;
    assign result.result_kind   = out_kind_reg;
    assign result.last_of_frame = out_last_reg;

endmodule
`default_nettype wire

// ----- rtl/core/websocket_frame_deframer.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// Receive-side frame parser: strips headers, unmasks payload, reports control.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                         | handshake
//  ---------+-----+-------------------------------------------------+----------
//  stream   | in  | rx_byte[7:0]                                    | valid/ready
//  result   | out | out_byte[7:0] frame_opcode[3:0] result_kind[2:0]| valid/ready
//           |     | last_of_frame                                   |
//
//  One byte per clock sustained while results are taken: the frame state
//  machine and 64-bit length countdown settle each byte between the input
//  register and the result register, and a byte's result shows on the
//  result port once it has passed the input register and then the result
//  register. Reset (rst_n low) returns to the first header byte with the
//  link open. A stalled result holds in the result register while the
//  input register still takes one more byte; further bytes wait for ready.
// ----------------------------------------------------------------------------
module websocket_frame_deframer (
    input  wire logic clk,
    input  wire logic rst_n,
    wsd_in_if.sink    stream,
    wsd_out_if.source result
);

    wsd_pkg::in_item_t item;
    logic              advance;

    // Hold the incoming byte until the parser can move it forward.
    wsd_in_stage u_in_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .stream  (stream),
        .advance (advance),
        .item    (item)
    );

    // Advance the frame state and load the result register.
    wsd_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item),
        .advance (advance),
        .result  (result)
    );

endmodule
`default_nettype wire

// ----- rtl/core/wsd_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wsd_checker
// Port-level checks on the deframer result channel.
// ----------------------------------------------------------------------------
module wsd_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] out_byte,
    input wire logic [3:0] frame_opcode,
    input wire logic [2:0] result_kind,
    input wire logic       last_of_frame
);

    // A stalled result holds its fields.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
        $stable(result_kind) && $stable(frame_opcode) && $stable(last_of_frame))
    else $error("stalled result changed");

    // Marker results carry a zero byte and end the frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (result_kind == wsd_pkg::KIND_EMPTY_DATA ||
        result_kind == wsd_pkg::KIND_CLOSE || result_kind == wsd_pkg::KIND_EMPTY_PING)
        |-> out_byte == 8'd0 && last_of_frame)
    else $error("marker result malformed");

    // Close results carry the close opcode.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (result_kind == wsd_pkg::KIND_CLOSE) |-> frame_opcode == wsd_pkg::OPC_CLOSE)
    else $error("close result with wrong opcode");

    // Once a close item is taken, nothing follows.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && result_kind == wsd_pkg::KIND_CLOSE |=> !out_valid)
    else $error("result after close");

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (result.valid),
    .out_ready     (result.ready),
    .out_byte      (result.out_byte),
    .frame_opcode  (result.frame_opcode),
    .result_kind   (result.result_kind),
    .last_of_frame (result.last_of_frame)
);
`default_nettype wire

// ----- tb/sv/tb_websocket_frame_deframer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_websocket_frame_deframer
// Drives a received byte stream into the frame deframer and checks every
// result item against a cycle-free frame parser kept in a scoreboard. The
// stream starts with hand-built frames and goes on with random frames and
// stray bytes. It ends with a close frame and bytes that must be ignored.
// Both handshakes stall at random.
// ----------------------------------------------------------------------------
module tb_websocket_frame_deframer;

    // Opcodes and header bits that the package does not name.
    localparam logic [3:0] OPC_CONT     = 4'h0;
    localparam logic [3:0] OPC_TEXT     = 4'h1;
    localparam logic [3:0] OPC_BINARY   = 4'h2;
    localparam logic [3:0] OPC_RESERVED = 4'hF;
    localparam logic [3:0] HDR_FIN      = 4'b1000;
    localparam logic [3:0] HDR_RSV_ONLY = 4'b0111;
    localparam logic       MASK_ON      = 1'b1;
    localparam logic       MASK_OFF     = 1'b0;

    // Byte totals at which each idling phase hands over to the next.
    localparam int unsigned PHASE1_BYTES = 600;
    localparam int unsigned PHASE2_BYTES = 1200;
    localparam int unsigned PHASE3_BYTES = 1780;

    localparam int unsigned DRAIN_LIMIT  = 20000;
    localparam int unsigned TAIL_CYCLES  = 20;
    localparam int unsigned REPORT_CAP   = 100;

    // Where the parser stands in the frame.
    typedef enum logic [2:0] {
        ST_OPCODE,
        ST_LENGTH,
        ST_EXT16,
        ST_EXT64,
        ST_KEY,
        ST_PAYLOAD
    } stream_state_t;

    // How a random frame encodes its payload length.
    typedef enum logic [1:0] {
        FORM_SHORT,
        FORM_EXT16,
        FORM_EXT64
    } len_form_t;

    typedef struct packed {
        logic [7:0] data;
        logic [3:0] opcode;
        logic [2:0] kind;
        logic       last;
    } ws_result_t;

    // Hand-built frames: payload extremes, every frame type but close, empty frames
    // ending on a length byte and on a key byte, unchecked header bits.
    localparam logic [7:0] DIRECTED [28] = '{
        // text, unmasked, two bytes 00 and FF
        {HDR_FIN, OPC_TEXT}, {MASK_OFF, 7'd2}, 8'h00, 8'hFF,
        // empty binary frame
        {HDR_FIN, OPC_BINARY}, {MASK_OFF, 7'd0},
        // empty ping
        {HDR_FIN, wsd_pkg::OPC_PING}, {MASK_OFF, 7'd0},
        // masked ping with one byte to echo
        {HDR_FIN, wsd_pkg::OPC_PING}, {MASK_ON, 7'd1}, 8'hFF, 8'h00, 8'hA5, 8'h5A, 8'h0F,
        // pong with payload, dropped
        {HDR_FIN, wsd_pkg::OPC_PONG}, {MASK_OFF, 7'd1}, 8'h33,
        // reserved opcode, FIN clear, reserved bits set, 16-bit zero length
        {HDR_RSV_ONLY, OPC_RESERVED}, {MASK_OFF, wsd_pkg::LEN_EXT16}, 8'h00, 8'h00,
        // masked empty continuation frame, ends on the last key byte
        {HDR_FIN, OPC_CONT}, {MASK_ON, 7'd0}, 8'h12, 8'h34, 8'h56, 8'h78
    };

    // ------------------------------------------------------------------------
    // Scoreboard: a copy of the frame parser that turns every accepted byte
    // into the result items it must cause, and a queue of those items.
    // ------------------------------------------------------------------------
    class ws_scoreboard;
        stream_state_t phase;
        logic [3:0]    opcode;
        logic          masked;
        logic [2:0]    ext_idx;
        logic [63:0]   remaining;
        logic [31:0]   key;
        logic [1:0]    key_pos;
        logic          link_open;
        ws_result_t    pending[$];
        int            errors;

        function new();
            phase     = ST_OPCODE;
            opcode    = '0;
            masked    = 1'b0;
            ext_idx   = '0;
            remaining = '0;
            key       = '0;
            key_pos   = '0;
            link_open = 1'b1;
            errors    = 0;
        endfunction

        function void queue_result(logic [7:0] data, logic [2:0] kind, logic last);
            pending.push_back(ws_result_t'{data: data, opcode: opcode, kind: kind,
                                           last: last});
        endfunction

        // Header complete: enter the payload, or close out an empty frame.
        function void header_done();
            key_pos = '0;
            if (remaining != 64'd0)
            begin
                phase = ST_PAYLOAD;
                return;
            end
            phase = ST_OPCODE;
            case (opcode)
                wsd_pkg::OPC_CLOSE:
                begin
                    link_open = 1'b0;
                    queue_result(8'h00, wsd_pkg::KIND_CLOSE, 1'b1);
                end
                wsd_pkg::OPC_PONG: ;
                wsd_pkg::OPC_PING: queue_result(8'h00, wsd_pkg::KIND_EMPTY_PING, 1'b1);
                default:           queue_result(8'h00, wsd_pkg::KIND_EMPTY_DATA, 1'b1);
            endcase
        endfunction

        // Length known: collect the key first if the frame is masked.
        function void length_done();
            if (masked)
            begin
                phase   = ST_KEY;
                key_pos = '0;
                key     = '0;
            end
            else
                header_done();
        endfunction

        function void note_input(logic [7:0] b);
            logic [7:0] key_byte;
            logic [7:0] plain;
            logic       fin;
            if (!link_open)
                return;
            case (phase)
                ST_LENGTH:
                begin
                    masked    = b[7];
                    ext_idx   = '0;
                    remaining = '0;
                    if (b[6:0] == wsd_pkg::LEN_EXT16)
                        phase = ST_EXT16;
                    else if (b[6:0] == wsd_pkg::LEN_EXT64)
                        phase = ST_EXT64;
                    else
                    begin
                        remaining = 64'(b[6:0]);
                        length_done();
                    end
                end
                ST_EXT16, ST_EXT64:
                begin
                    remaining = {remaining[55:0], b};
                    ext_idx   = ext_idx + 3'd1;
                    if ((phase == ST_EXT16 && ext_idx == 3'd2) ||
                        (phase == ST_EXT64 && ext_idx == 3'd0))
                        length_done();
                end
                ST_KEY:
                begin
                    key[{key_pos, 3'b000} +: 8] = b;
                    if (key_pos == 2'd3)
                        header_done();
                    else
                        key_pos = key_pos + 2'd1;
                end
                ST_PAYLOAD:
                begin
                    key_byte  = masked ? key[{key_pos, 3'b000} +: 8] : 8'h00;
                    plain     = b ^ key_byte;
                    key_pos   = key_pos + 2'd1;
                    remaining = remaining - 64'd1;
                    fin       = (remaining == 64'd0);
                    if (fin)
                        phase = ST_OPCODE;
                    case (opcode)
                        wsd_pkg::OPC_CLOSE:
                        begin
                            if (fin)
                            begin
                                link_open = 1'b0;
                                queue_result(8'h00, wsd_pkg::KIND_CLOSE, 1'b1);
                            end
                        end
                        wsd_pkg::OPC_PONG: ;
                        wsd_pkg::OPC_PING: queue_result(plain, wsd_pkg::KIND_PING_BYTE, fin);
                        default:           queue_result(plain, wsd_pkg::KIND_DATA, fin);
                    endcase
                end
                default:
                begin
                    opcode = b[3:0];
                    phase  = ST_LENGTH;
                end
            endcase
        endfunction

        function string show(ws_result_t r);
            return $sformatf("byte %02h opcode %0h kind %0d last %0b",
                             r.data, r.opcode, r.kind, r.last);
        endfunction

        // Count every mismatch; keep the log short on a badly broken run.
        task report(string msg);
            errors++;
            if (errors <= REPORT_CAP)
                $display("%0t mismatch: %s", $realtime, msg);
        endtask

        task check_result(ws_result_t got);
            ws_result_t want;
            if (pending.size() == 0)
            begin
                report($sformatf("result with nothing pending: %s", show(got)));
                return;
            end
            want = pending.pop_front();
            if (got.data !== want.data || got.opcode !== want.opcode ||
                got.kind !== want.kind || got.last !== want.last)
                report($sformatf("got %s, want %s", show(got), show(want)));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, channels and the block.
    // ------------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    wsd_in_if  stream_if ();
    wsd_out_if result_if ();

    websocket_frame_deframer dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (stream_if),
        .result (result_if)
    );

    ws_scoreboard sb = new();
    int           src_idle;
    int           sink_idle;
    int unsigned  bytes_sent;
    bit           keep_open;

    initial
    begin
        rst_n             = 1'b0;
        stream_if.valid   = 1'b0;
        stream_if.rx_byte = 8'h00;
        result_if.ready   = 1'b0;
        src_idle          = 0;
        sink_idle         = 0;
        bytes_sent        = 0;
        keep_open         = 1'b1;
    end

    // Receiver: decide ready at each falling edge, stalling at random.
    always @(negedge clk)
    begin
        result_if.ready <= (rst_n === 1'b1) && ($urandom_range(99) >= sink_idle);
    end

    // Take each accepted result at the rising edge and check it.
    always @(posedge clk)
    begin
        if (rst_n && result_if.valid && result_if.ready)
            sb.check_result(ws_result_t'{data:   result_if.out_byte,
                                         opcode: result_if.frame_opcode,
                                         kind:   result_if.result_kind,
                                         last:   result_if.last_of_frame});
    end

    // ------------------------------------------------------------------------
    // Stimulus tasks. Each one starts and ends at a falling edge.
    // ------------------------------------------------------------------------

    // Offer one byte, idling at random first, and hold it until accepted.
    task automatic push_byte(input logic [7:0] value);
        logic [7:0] b;
        b = value;
        // Hold the link open until the final close: a close opcode landing
        // on a header byte becomes a ping.
        if (keep_open && sb.phase == ST_OPCODE && b[3:0] == wsd_pkg::OPC_CLOSE)
            b[3:0] = wsd_pkg::OPC_PING;
        while ($urandom_range(99) < src_idle)
        begin
            stream_if.valid <= 1'b0;
            @(negedge clk);
        end
        stream_if.valid   <= 1'b1;
        stream_if.rx_byte <= b;
        @(posedge clk);
        while (!stream_if.ready)
            @(posedge clk);
        sb.note_input(b);
        bytes_sent++;
        @(negedge clk);
    endtask

    // One well-formed frame with random opcode, length form, mask and payload.
    // Lengths stay mostly small; a few go past the 7-bit range.
    task automatic push_random_frame();
        logic [3:0]  opc;
        logic [63:0] len;
        logic        masked;
        int unsigned pick;
        len_form_t   form;
        opc  = 4'($urandom_range(15));
        pick = $urandom_range(99);
        if (pick < 15)
            len = 64'd0;
        else if (pick < 80)
            len = 64'($urandom_range(1, 12));
        else if (pick < 96)
            len = 64'($urandom_range(13, 125));
        else
            len = 64'($urandom_range(126, 300));
        pick = $urandom_range(9);
        if (len > 64'd125)
            form = (pick < 5) ? FORM_EXT16 : FORM_EXT64;
        else if (pick < 8)
            form = FORM_SHORT;
        else
            form = (pick == 8) ? FORM_EXT16 : FORM_EXT64;
        masked = 1'($urandom_range(1));

        push_byte({4'($urandom), opc});
        case (form)
            FORM_SHORT:
                push_byte({masked, len[6:0]});
            FORM_EXT16:
            begin
                push_byte({masked, wsd_pkg::LEN_EXT16});
                push_byte(len[15:8]);
                push_byte(len[7:0]);
            end
            default:
            begin
                push_byte({masked, wsd_pkg::LEN_EXT64});
                for (int i = 7; i >= 0; i--)
                    push_byte(len[8*i +: 8]);
            end
        endcase
        if (masked)
            repeat (4) push_byte(8'($urandom));
        repeat (int'(len)) push_byte(8'($urandom));
    endtask

    // Stray bytes that break the frame layout, then finish whatever frame
    // they opened. Extended length bytes are held low except the last one,
    // so a garbage length never grows past 255 bytes.
    task automatic push_noise();
        int unsigned n;
        int unsigned k;
        logic [7:0]  b;
        n = $urandom_range(1, 6);
        k = 0;
        while (k < n || sb.phase != ST_OPCODE)
        begin
            b = 8'($urandom);
            if (sb.phase == ST_EXT64 && sb.ext_idx != 3'd7)
                b = 8'h00;
            if (sb.phase == ST_EXT16 && sb.ext_idx == 3'd0)
                b = 8'h00;
            push_byte(b);
            k++;
        end
    endtask

    task automatic run_random(input int unsigned target);
        while (bytes_sent < target)
        begin
            if ($urandom_range(99) < 15)
                push_noise();
            else
                push_random_frame();
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial
    begin : main
        int unsigned drain_cycles;
        logic [6:0]  close_len;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Slow receiver: results pile up against a busy sender.
        src_idle  = 24;
        sink_idle = 83;
        foreach (DIRECTED[i])
            push_byte(DIRECTED[i]);
        run_random(PHASE1_BYTES);

        // Slow sender, mostly ready receiver.
        src_idle  = 83;
        sink_idle = 24;
        run_random(PHASE2_BYTES);

        // Full rate on both sides.
        src_idle  = 0;
        sink_idle = 0;
        run_random(PHASE3_BYTES);

        // Close the link: one close item on the byte that ends the frame,
        // then every later byte must be ignored.
        keep_open = 1'b0;
        close_len = 7'($urandom_range(0, 5));
        push_byte({HDR_FIN, wsd_pkg::OPC_CLOSE});
        push_byte({MASK_ON, close_len});
        repeat (4) push_byte(8'($urandom));
        repeat (int'(close_len)) push_byte(8'($urandom));
        push_byte({HDR_FIN, OPC_TEXT});
        push_byte({MASK_OFF, 7'd1});
        push_byte(8'h41);
        repeat (6) push_byte(8'($urandom));
        stream_if.valid <= 1'b0;

        // Drain the result queue, then watch a few more cycles for strays.
        drain_cycles = 0;
        while (sb.pending.size() != 0 && drain_cycles < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain_cycles++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.pending.size() != 0)
            sb.report($sformatf("%0d result items never arrived", sb.pending.size()));

        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #20_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
